@@ sv/mcs_pkg.sv @@
// Shared types, constants and helpers of the microcoded cycle-step block.
package mcs_pkg;

	localparam int MEM_WORDS_DEF   = 32768;
	localparam int MEM_LATENCY_DEF = 5;
	localparam int CS_ROWS         = 64;
	localparam int NUM_REGS        = 8;
	localparam int CS_AW           = 6;
	localparam int REG_AW          = 3;
	localparam int CW_BITS         = 35;

	localparam logic [5:0] START_STATE = 6'd18;
	localparam logic [2:0] CC_RESET    = 3'b010;
	localparam logic [2:0] CC_N        = 3'b100;
	localparam logic [2:0] CC_Z        = 3'b010;
	localparam logic [2:0] CC_P        = 3'b001;

	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_CS   = 2'd1,
		FUNC_MEM  = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	localparam logic [1:0] COND_J     = 2'd0;
	localparam logic [1:0] COND_READY = 2'd1;
	localparam logic [1:0] COND_BEN   = 2'd2;
	localparam logic [1:0] COND_IR11  = 2'd3;

	localparam logic [1:0] PCMUX_INC   = 2'd0;
	localparam logic [1:0] PCMUX_BUS   = 2'd1;
	localparam logic [1:0] PCMUX_ADDER = 2'd2;
	localparam logic [1:0] PCMUX_HOLD  = 2'd3;

	localparam logic [1:0] A2_ZERO = 2'd0;
	localparam logic [1:0] A2_OFF6 = 2'd1;
	localparam logic [1:0] A2_OFF9 = 2'd2;
	localparam logic [1:0] A2_OFF11 = 2'd3;

	localparam logic [1:0] ALU_ADD  = 2'd0;
	localparam logic [1:0] ALU_AND  = 2'd1;
	localparam logic [1:0] ALU_XOR  = 2'd2;
	localparam logic [1:0] ALU_PASS = 2'd3;

	// Microinstruction layout, most significant field first.
	typedef struct packed {
		logic       ird;
		logic [1:0] cond;
		logic [5:0] j;
		logic       ld_mar;
		logic       ld_mdr;
		logic       ld_ir;
		logic       ld_ben;
		logic       ld_reg;
		logic       ld_cc;
		logic       ld_pc;
		logic       drv_pc;
		logic       drv_mdr;
		logic       drv_alu;
		logic       drv_addr;
		logic       drv_shift;
		logic [1:0] pcmux;
		logic       drmux;
		logic       sr1mux;
		logic       addr1mux;
		logic [1:0] addr2mux;
		logic       marmux;
		logic [1:0] aluk;
		logic       mio_en;
		logic       r_w;
		logic       wide_xfer;
		logic       lshf1;
	} cw_t;

	// Sign-extend the low byte of a word.
	function automatic logic [15:0] sext8(input logic [7:0] v);
		return {{8{v[7]}}, v};
	endfunction

endpackage

@@ sv/mcs_ram.sv @@
// Generic single-port synchronous RAM with registered read.
module mcs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read one entry per cycle; read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

@@ sv/microcoded_cpu_cycle_step.sv @@
// Top level: microcoded 16-bit datapath, one machine clock per tick transaction.
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+---------------------------------------------
//  item      | item_valid / item_ready     | func, cs_row, cs_word, mem_word_addr, mem_data
//  result    | result_valid / result_ready | pc_value .. halted
//  config    | cfg_we (no wait)            | cfg_wdata = start_pc
//
// A tick transaction reads the control store, the register file copies and main memory
// (all synchronous RAMs) on accept in ST_IDLE, then computes and writes back in ST_EXEC.
// After reset a clearing pass zeroes every word of main memory, with item_ready low.
// A finished result waits in the output register; the next transaction is accepted
// meanwhile and stalls in ST_EXEC only if that register is still full.
module microcoded_cpu_cycle_step #(
	parameter int MEM_WORDS   = mcs_pkg::MEM_WORDS_DEF,
	parameter int MEM_LATENCY = mcs_pkg::MEM_LATENCY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  func,
	input  logic [5:0]  cs_row,
	input  logic [34:0] cs_word,
	input  logic [14:0] mem_word_addr,
	input  logic [15:0] mem_data,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [15:0] pc_value,
	output logic [15:0] ir_value,
	output logic [15:0] bus_value,
	output logic [15:0] mar_value,
	output logic [15:0] mdr_value,
	output logic [5:0]  micro_state_out,
	output logic [2:0]  cond_nzp,
	output logic        halted
);

	localparam int MAW = $clog2(MEM_WORDS);
	localparam int NUM_REGS_W = mcs_pkg::NUM_REGS;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	state_t state_q;

	logic [15:0] start_pc_q;
	logic [15:0] pc_q, ir_q, mar_q, mdr_q;
	logic [2:0]  cc_q;
	logic        ben_q, rdy_q, started_q;
	logic [2:0]  cnt_q;
	logic [5:0]  ustate_q;
	logic [NUM_REGS_W-1:0] reg_valid_q;
	logic [MAW-1:0] clr_q;
	logic        exec_s1;

	logic accept, commit, out_free;
	logic [15:0] eff_pc;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign out_free   = !result_valid || result_ready;
	assign commit     = (state_q == ST_EXEC) && out_free;
	assign eff_pc     = started_q ? pc_q : start_pc_q;

	// Control store
	logic        cs_we, cs_re;
	logic [mcs_pkg::CS_AW-1:0] cs_addr;
	logic [34:0] cs_rdata;

	assign cs_we   = accept && (func == mcs_pkg::FUNC_CS);
	assign cs_re   = accept && (func == mcs_pkg::FUNC_TICK);
	assign cs_addr = cs_we ? cs_row : ustate_q;

	mcs_ram #(.WIDTH(mcs_pkg::CW_BITS), .DEPTH(mcs_pkg::CS_ROWS)) u_cs (
		.clk(clk), .we(cs_we), .re(cs_re), .addr(cs_addr),
		.wdata(cs_word), .rdata(cs_rdata)
	);

	mcs_pkg::cw_t cw;
	assign cw = mcs_pkg::cw_t'(cs_rdata);

	// Register file: three copies, one per read field of IR
	logic        rf_we;
	logic [2:0]  rf_wa;
	logic [15:0] rf_wd;
	logic [15:0] rd_a, rd_b, rd_c;
	logic [15:0] reg_a, reg_b, reg_c;

	mcs_ram #(.WIDTH(16), .DEPTH(mcs_pkg::NUM_REGS)) u_rf_a (
		.clk(clk), .we(rf_we), .re(cs_re), .addr(rf_we ? rf_wa : ir_q[11:9]),
		.wdata(rf_wd), .rdata(rd_a)
	);
	mcs_ram #(.WIDTH(16), .DEPTH(mcs_pkg::NUM_REGS)) u_rf_b (
		.clk(clk), .we(rf_we), .re(cs_re), .addr(rf_we ? rf_wa : ir_q[8:6]),
		.wdata(rf_wd), .rdata(rd_b)
	);
	mcs_ram #(.WIDTH(16), .DEPTH(mcs_pkg::NUM_REGS)) u_rf_c (
		.clk(clk), .we(rf_we), .re(cs_re), .addr(rf_we ? rf_wa : ir_q[2:0]),
		.wdata(rf_wd), .rdata(rd_c)
	);

	// Never-written registers read as zero
	assign reg_a = reg_valid_q[ir_q[11:9]] ? rd_a : 16'h0000;
	assign reg_b = reg_valid_q[ir_q[8:6]]  ? rd_b : 16'h0000;
	assign reg_c = reg_valid_q[ir_q[2:0]]  ? rd_c : 16'h0000;

	// Main memory
	logic           mem_we, mem_re;
	logic [MAW-1:0] mem_addr;
	logic [15:0]    mem_wd, mem_rdata;
	logic           store_now;
	logic [15:0]    new_word;

	assign mem_re = cs_re;

	always_comb begin
		mem_we   = 1'b0;
		mem_addr = mar_q[MAW:1];
		mem_wd   = new_word;
		priority if (state_q == ST_CLEAR) begin
			mem_we   = 1'b1;
			mem_addr = clr_q;
			mem_wd   = 16'h0000;
		end else if (accept && (func == mcs_pkg::FUNC_MEM)) begin
			mem_we   = 1'b1;
			mem_addr = mem_word_addr[MAW-1:0];
			mem_wd   = mem_data;
		end else if (commit && exec_s1 && store_now) begin
			mem_we   = 1'b1;
		end else begin
			mem_we   = 1'b0;
		end
	end

	mcs_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_mem (
		.clk(clk), .we(mem_we), .re(mem_re), .addr(mem_addr),
		.wdata(mem_wd), .rdata(mem_rdata)
	);

	// Datapath of one machine clock
	logic [15:0] sr1, sr2, a1, a2, a2s, sum, alu, shf, mux, mdrout, bus;
	logic [15:0] pc_n, mdr_n, mem_word;
	logic [2:0]  cc_n, cnt_n;
	logic        ben_n, rdy_n;
	logic [5:0]  ustate_n;
	logic [3:0]  amt;

	always_comb begin
		sr1 = cw.sr1mux ? reg_b : reg_a;
		sr2 = ir_q[5] ? {{11{ir_q[4]}}, ir_q[4:0]} : reg_c;
		a1  = cw.addr1mux ? reg_b : pc_q;
		unique case (cw.addr2mux)
			mcs_pkg::A2_ZERO: a2 = 16'h0000;
			mcs_pkg::A2_OFF6: a2 = {{10{ir_q[5]}}, ir_q[5:0]};
			mcs_pkg::A2_OFF9: a2 = {{7{ir_q[8]}}, ir_q[8:0]};
			default:          a2 = {{5{ir_q[10]}}, ir_q[10:0]};
		endcase
		a2s = cw.lshf1 ? {a2[14:0], 1'b0} : a2;
		sum = a1 + a2s;

		unique case (cw.aluk)
			mcs_pkg::ALU_ADD: alu = sr1 + sr2;
			mcs_pkg::ALU_AND: alu = sr1 & sr2;
			mcs_pkg::ALU_XOR: alu = sr1 ^ sr2;
			default:          alu = sr1;
		endcase

		amt = ir_q[3:0];
		priority if (!ir_q[4]) begin
			shf = sr1 << amt;
		end else if (ir_q[5]) begin
			shf = 16'($signed(sr1) >>> amt);
		end else begin
			shf = sr1 >> amt;
		end

		mux = cw.marmux ? sum : {7'd0, ir_q[7:0], 1'b0};
		if (cw.wide_xfer) begin
			mdrout = mdr_q;
		end else begin
			mdrout = mar_q[0] ? mcs_pkg::sext8(mdr_q[15:8]) : mcs_pkg::sext8(mdr_q[7:0]);
		end

		// Drive the bus by gate priority
		priority if (cw.drv_addr) begin
			bus = mux;
		end else if (cw.drv_pc) begin
			bus = pc_q;
		end else if (cw.drv_alu) begin
			bus = alu;
		end else if (cw.drv_shift) begin
			bus = shf;
		end else if (cw.drv_mdr) begin
			bus = mdrout;
		end else begin
			bus = 16'h0000;
		end

		// Advance the memory handshake
		cnt_n     = cnt_q;
		rdy_n     = rdy_q;
		store_now = 1'b0;
		if (cw.mio_en) begin
			cnt_n = cnt_q + 3'd1;
			if (cnt_n == 3'(MEM_LATENCY - 1)) begin
				rdy_n = 1'b1;
			end else if (cnt_n >= 3'(MEM_LATENCY)) begin
				store_now = cw.r_w;
				cnt_n     = 3'd0;
				rdy_n     = 1'b0;
			end
		end
		if (cw.wide_xfer) begin
			new_word = mdr_q;
		end else if (mar_q[0]) begin
			new_word = {mdr_q[7:0], mem_rdata[7:0]};
		end else begin
			new_word = {mem_rdata[15:8], mdr_q[7:0]};
		end
		mem_word = store_now ? new_word : mem_rdata;

		mdr_n = mdr_q;
		if (cw.ld_mdr) begin
			if (!cw.mio_en) begin
				mdr_n = cw.wide_xfer ? bus : mcs_pkg::sext8(bus[7:0]);
			end else if (rdy_q) begin
				mdr_n = mem_word;
			end
		end

		ben_n = cw.ld_ben ? ((ir_q[11] & cc_q[2]) | (ir_q[10] & cc_q[1]) | (ir_q[9] & cc_q[0]))
		                  : ben_q;
		if (!cw.ld_cc) begin
			cc_n = cc_q;
		end else if (bus == 16'h0000) begin
			cc_n = mcs_pkg::CC_Z;
		end else if (bus[15]) begin
			cc_n = mcs_pkg::CC_N;
		end else begin
			cc_n = mcs_pkg::CC_P;
		end

		pc_n = pc_q;
		if (cw.ld_pc) begin
			unique case (cw.pcmux)
				mcs_pkg::PCMUX_INC:   pc_n = pc_q + 16'd2;
				mcs_pkg::PCMUX_BUS:   pc_n = bus;
				mcs_pkg::PCMUX_ADDER: pc_n = sum;
				default:              pc_n = pc_q;
			endcase
		end

		// Pick the next micro state
		if (cw.ird) begin
			ustate_n = {2'b00, ir_q[15:12]};
		end else begin
			unique case (cw.cond)
				mcs_pkg::COND_READY: ustate_n = cw.j | {4'd0, rdy_q, 1'b0};
				mcs_pkg::COND_BEN:   ustate_n = cw.j | {3'd0, ben_q, 2'b00};
				mcs_pkg::COND_IR11:  ustate_n = cw.j | {5'd0, ir_q[11]};
				default:             ustate_n = cw.j;
			endcase
		end
	end

	assign rf_we = commit && exec_s1 && cw.ld_reg;
	assign rf_wa = cw.drmux ? 3'd7 : ir_q[11:9];
	assign rf_wd = bus;

	// Sequence clearing, accept and write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			start_pc_q  <= 16'h0000;
			pc_q        <= 16'h0000;
			ir_q        <= 16'h0000;
			mar_q       <= 16'h0000;
			mdr_q       <= 16'h0000;
			cc_q        <= mcs_pkg::CC_RESET;
			ben_q       <= 1'b0;
			rdy_q       <= 1'b0;
			cnt_q       <= 3'd0;
			ustate_q    <= mcs_pkg::START_STATE;
			started_q   <= 1'b0;
			reg_valid_q <= '0;
			exec_s1     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				start_pc_q <= cfg_wdata;
			end
			// Drop the result once taken, unless a new one lands now
			if (result_valid && result_ready && !commit) begin
				result_valid <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MAW'(MEM_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
						exec_s1 <= (func == mcs_pkg::FUNC_TICK) && (eff_pc != 16'h0000);
						if (func == mcs_pkg::FUNC_TICK) begin
							pc_q      <= eff_pc;
							started_q <= 1'b1;
						end
					end
				end
				ST_EXEC: begin
					if (commit) begin
						state_q      <= ST_IDLE;
						result_valid <= 1'b1;
						if (exec_s1) begin
							pc_q     <= pc_n;
							mdr_q    <= mdr_n;
							cc_q     <= cc_n;
							ben_q    <= ben_n;
							rdy_q    <= rdy_n;
							cnt_q    <= cnt_n;
							ustate_q <= ustate_n;
							if (cw.ld_mar) begin
								mar_q <= bus;
							end
							if (cw.ld_ir) begin
								ir_q <= bus;
							end
							if (cw.ld_reg) begin
								reg_valid_q[rf_wa] <= 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (commit) begin
			if (exec_s1) begin
				pc_value  <= pc_n;
				ir_value  <= cw.ld_ir ? bus : ir_q;
				bus_value <= bus;
				mar_value <= cw.ld_mar ? bus : mar_q;
				mdr_value <= mdr_n;
				micro_state_out <= ustate_n;
				cond_nzp  <= cc_n;
				halted    <= started_q && (pc_n == 16'h0000);
			end else begin
				pc_value  <= pc_q;
				ir_value  <= ir_q;
				bus_value <= 16'h0000;
				mar_value <= mar_q;
				mdr_value <= mdr_q;
				micro_state_out <= ustate_q;
				cond_nzp  <= cc_q;
				halted    <= started_q && (pc_q == 16'h0000);
			end
		end
	end

endmodule
